[sv/acf_pkg.sv]
// Shared types, character codes and frame constants for the command frame parser.
`default_nettype none

package acf_pkg;

    // Default receive buffer depth; the fill counter flushes at depth minus one.
    localparam int ACF_BUFFER_DEPTH = 64;

    localparam int SETTING_COUNT = 6;
    localparam int FLAG_W        = 10;
    localparam int VALUE_W       = 10;
    localparam int KIND_W        = 4;
    localparam int LEN_W         = 4;

    // Frame kinds reported with each result.
    localparam logic [KIND_W-1:0] KIND_NONE  = 4'd0;
    localparam logic [KIND_W-1:0] KIND_RAH   = 4'd1;
    localparam logic [KIND_W-1:0] KIND_RAL   = 4'd2;
    localparam logic [KIND_W-1:0] KIND_RCH   = 4'd3;
    localparam logic [KIND_W-1:0] KIND_RCL   = 4'd4;
    localparam logic [KIND_W-1:0] KIND_RSH   = 4'd5;
    localparam logic [KIND_W-1:0] KIND_RSL   = 4'd6;
    localparam logic [KIND_W-1:0] KIND_CLOSE = 4'd7;
    localparam logic [KIND_W-1:0] KIND_FAR   = 4'd8;
    localparam logic [KIND_W-1:0] KIND_OFF   = 4'd9;
    localparam logic [KIND_W-1:0] KIND_ON    = 4'd10;
    localparam logic [KIND_W-1:0] KIND_BAD   = 4'd11;

    // Flag bit positions above the six setting arrivals.
    localparam int FLAG_CLOSE = 6;
    localparam int FLAG_FAR   = 7;
    localparam int FLAG_OFF   = 8;
    localparam int FLAG_ON    = 9;

    // A clear request drops the setting arrivals and the key off/on flags.
    localparam logic [FLAG_W-1:0] CLEAR_MASK = 10'h33F;

    // Character codes.
    localparam logic [7:0] CH_OPEN  = 8'h3C;
    localparam logic [7:0] CH_CLOSE = 8'h3E;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Key frame bodies, first character in the top byte.
    localparam logic [47:0] PAT_KEY_CLOSE = "WK0001";
    localparam logic [47:0] PAT_KEY_FAR   = "WK0000";
    localparam logic [47:0] PAT_KEY_OFF   = "WK0010";
    localparam logic [47:0] PAT_KEY_ON    = "WK0011";

    // Result of decoding one closed frame.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [2:0]         slot;
        logic [VALUE_W-1:0] value;
    } t_decode;

endpackage : acf_pkg

`default_nettype wire

[sv/acf_frame_decode.sv]
// Combinational decoder for the six characters captured between '<' and '>'.
`default_nettype none

module acf_frame_decode
    import acf_pkg::*;
(
    input  wire logic [47:0]      i_chars,
    input  wire logic [LEN_W-1:0] i_len,
    output t_decode               o_dec
);

    logic [7:0] c0, c1, c2, c3, c4, c5;
    logic [1:0] group_sel;
    logic       group_ok;
    logic       half_sel;
    logic       half_ok;
    logic       digits_ok;
    logic [2:0] slot;

    assign {c0, c1, c2, c3, c4, c5} = i_chars;

    always_comb begin
        group_sel = 2'd0;
        group_ok  = 1'b1;
        unique case (c1)
            CH_A:    group_sel = 2'd0;
            CH_C:    group_sel = 2'd1;
            CH_S:    group_sel = 2'd2;
            default: group_ok  = 1'b0;
        endcase
        half_sel = 1'b0;
        half_ok  = 1'b1;
        unique case (c2)
            CH_H:    half_sel = 1'b0;
            CH_L:    half_sel = 1'b1;
            default: half_ok  = 1'b0;
        endcase
    end

    assign digits_ok = (c3 >= CH_ZERO) && (c3 <= CH_NINE) &&
                       (c4 >= CH_ZERO) && (c4 <= CH_NINE) &&
                       (c5 >= CH_ZERO) && (c5 <= CH_NINE);
    assign slot      = {group_sel, half_sel};

    always_comb begin
        o_dec.kind  = KIND_BAD;
        o_dec.slot  = slot;
        // Digits are 0x30..0x39, so the low nibble is the digit value.
        o_dec.value = VALUE_W'(c3[3:0]) * 10'd100 + VALUE_W'(c4[3:0]) * 10'd10 +
                      VALUE_W'(c5[3:0]);
        if (i_len == LEN_W'(SETTING_COUNT)) begin
            if (c0 == CH_R) begin
                if (group_ok && half_ok && digits_ok) begin
                    o_dec.kind = KIND_W'(slot) + 4'd1;
                end
            end else if (i_chars == PAT_KEY_CLOSE) begin
                o_dec.kind = KIND_CLOSE;
            end else if (i_chars == PAT_KEY_FAR) begin
                o_dec.kind = KIND_FAR;
            end else if (i_chars == PAT_KEY_OFF) begin
                o_dec.kind = KIND_OFF;
            end else if (i_chars == PAT_KEY_ON) begin
                o_dec.kind = KIND_ON;
            end
        end
    end

endmodule : acf_frame_decode

`default_nettype wire

[sv/ascii_command_frame_parser.sv]
// A result is registered and appears in the cycle after its transaction is accepted on the input side.
// Throughput: one byte or clear request per cycle while the output side keeps up; the single result register sets this.
// Out of reset, the input side stalls only while a result is held by a stalled output side.
// Reset is synchronous and active low; it clears the frame state, the flags and the
// six stored settings, and the input side stalls while reset is held.
`default_nettype none

module ascii_command_frame_parser
    import acf_pkg::*;
#(
    parameter int BUFFER_DEPTH = ACF_BUFFER_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_mode,
    input  wire logic [7:0]         i_rx_byte,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [KIND_W-1:0]       o_frame_kind,
    output logic                    o_buffer_flushed,
    output logic [FLAG_W-1:0]       o_arrival_flags,
    output logic                    o_all_settings_received,
    output logic [VALUE_W-1:0]      o_air_direction,
    output logic [VALUE_W-1:0]      o_air_speed,
    output logic [VALUE_W-1:0]      o_seat_height,
    output logic [VALUE_W-1:0]      o_seat_lateral,
    output logic [VALUE_W-1:0]      o_side_height,
    output logic [VALUE_W-1:0]      o_side_lateral
);

    // The fill counter never holds more than BUFFER_DEPTH - 2.
    localparam int FILL_W = $clog2(BUFFER_DEPTH);
    localparam logic [FILL_W-1:0] FILL_LIMIT = FILL_W'(BUFFER_DEPTH - 1);

    // Frame parsing state.
    logic                r_open;
    logic                n_open;
    logic [LEN_W-1:0]    r_len;
    logic [LEN_W-1:0]    n_len;
    logic [FILL_W-1:0]   r_fill;
    logic [FILL_W-1:0]   n_fill;
    logic [7:0]          r_chars [SETTING_COUNT];
    logic                n_wr_char;

    // Architectural state that is also the result payload.
    logic [FLAG_W-1:0]   r_flags;
    logic [FLAG_W-1:0]   n_flags;
    logic [VALUE_W-1:0]  r_values [SETTING_COUNT];
    logic                n_wr_value;

    // Result register.
    logic                r_out_valid;
    logic [KIND_W-1:0]   r_kind;
    logic [KIND_W-1:0]   n_kind;
    logic                r_flushed;
    logic                n_flushed;

    logic                accept;
    t_decode             dec;

    // Out of reset, the input may advance whenever the result register is empty or is being taken
    // in this cycle, so a new transaction lands each cycle the output side keeps up.
    assign o_in_stall = !i_rst_n || (r_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;

    acf_frame_decode u_decode (
        .i_chars ({r_chars[0], r_chars[1], r_chars[2], r_chars[3], r_chars[4], r_chars[5]}),
        .i_len   (r_len),
        .o_dec   (dec)
    );

    always_comb begin
        n_open     = r_open;
        n_len      = r_len;
        n_fill     = r_fill;
        n_flags    = r_flags;
        n_kind     = KIND_NONE;
        n_flushed  = 1'b0;
        n_wr_char  = 1'b0;
        n_wr_value = 1'b0;
        if (i_mode) begin
            // Clear request: the buffer is left alone and the byte is ignored.
            n_flags = r_flags & ~CLEAR_MASK;
        end else begin
            n_fill = r_fill + 1'b1;
            if (!r_open) begin
                // Bytes before the opening '<' are only counted.
                if (i_rx_byte == CH_OPEN) begin
                    n_open = 1'b1;
                    n_len  = '0;
                end
            end else if (i_rx_byte == CH_CLOSE) begin
                n_kind = dec.kind;
                unique case (dec.kind) inside
                    KIND_RAH, KIND_RAL, KIND_RCH, KIND_RCL, KIND_RSH, KIND_RSL: begin
                        n_wr_value          = 1'b1;
                        n_flags[dec.slot]   = 1'b1;
                    end
                    KIND_CLOSE: begin
                        n_flags[FLAG_CLOSE] = 1'b1;
                        n_flags[FLAG_FAR]   = 1'b0;
                    end
                    KIND_FAR: begin
                        n_flags[FLAG_FAR]   = 1'b1;
                        n_flags[FLAG_CLOSE] = 1'b0;
                    end
                    KIND_OFF: begin
                        n_flags[FLAG_OFF]   = 1'b1;
                    end
                    KIND_ON: begin
                        n_flags[FLAG_ON]    = 1'b1;
                    end
                    default: begin
                        n_flags = r_flags;
                    end
                endcase
                // Every closed frame empties the buffer.
                n_open = 1'b0;
                n_len  = '0;
                n_fill = '0;
            end else begin
                // Only the first six characters are kept; the length saturates.
                n_wr_char = (r_len < LEN_W'(SETTING_COUNT));
                if (r_len != {LEN_W{1'b1}}) begin
                    n_len = r_len + 1'b1;
                end
            end
            // A full buffer is flushed, dropping any half-received frame.
            if (n_fill >= FILL_LIMIT) begin
                n_fill    = '0;
                n_open    = 1'b0;
                n_len     = '0;
                n_flushed = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_len       <= '0;
            r_fill      <= '0;
            r_flags     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < SETTING_COUNT; i++) begin
                r_values[i] <= '0;
            end
        end else begin
            if (accept) begin
                r_open      <= n_open;
                r_len       <= n_len;
                r_fill      <= n_fill;
                r_flags     <= n_flags;
                r_out_valid <= 1'b1;
                if (n_wr_value) begin
                    r_values[dec.slot] <= dec.value;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Captured characters and result codes are plain payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind    <= n_kind;
            r_flushed <= n_flushed;
            if (n_wr_char) begin
                r_chars[r_len[2:0]] <= i_rx_byte;
            end
        end
    end

    // The state only moves together with the result register, so the stored flags
    // and settings are the result payload and hold still while the output stalls.
    assign o_out_valid             = r_out_valid;
    assign o_frame_kind            = r_kind;
    assign o_buffer_flushed        = r_flushed;
    assign o_arrival_flags         = r_flags;
    assign o_all_settings_received = &r_flags[SETTING_COUNT-1:0];
    assign o_air_direction         = r_values[0];
    assign o_air_speed             = r_values[1];
    assign o_seat_height           = r_values[2];
    assign o_seat_lateral          = r_values[3];
    assign o_side_height           = r_values[4];
    assign o_side_lateral          = r_values[5];

endmodule : ascii_command_frame_parser

`default_nettype wire

[sv/acf_checker.sv]
// Port-level checker for the command frame parser and its bind to the top level.
`default_nettype none

module acf_checker
    import acf_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire logic                i_mode,
    input wire logic                o_out_valid,
    input wire logic [KIND_W-1:0]   o_frame_kind,
    input wire logic                o_buffer_flushed,
    input wire logic [FLAG_W-1:0]   o_arrival_flags,
    input wire logic                o_all_settings_received
);

    // An accepted transaction always yields a result on the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted transaction produced no result");

    // Close and far are mutually exclusive.
    a_close_far: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_arrival_flags[FLAG_CLOSE] && o_arrival_flags[FLAG_FAR]))
        else $error("close and far flags both set");

    // A flush never coincides with a closed frame.
    a_flush_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_buffer_flushed) |-> (o_frame_kind == KIND_NONE))
        else $error("flush reported together with a frame");

    // A clear request keeps the close and far flags but drops the off and on flags.
    a_clear_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_mode) |=>
            (!o_arrival_flags[FLAG_OFF] && !o_arrival_flags[FLAG_ON] &&
             !o_all_settings_received && o_frame_kind == KIND_NONE))
        else $error("clear request left flags set");

endmodule : acf_checker

bind ascii_command_frame_parser acf_checker u_acf_checker (.*);

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the ASCII command frame parser, with its own model of the parser.
`default_nettype none

module tb_top;
    import acf_pkg::*;

    // The parser is built at its default depth, so a flush comes after 63 unframed bytes.
    localparam int DEPTH = ACF_BUFFER_DEPTH;

    // Input transaction kinds on i_mode.
    localparam logic MODE_BYTE  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    // Cycles with no transaction on either side before the run is declared hung.
    localparam int HANG_LIMIT = 1000;

    // Expected contents of one result transaction.
    typedef struct packed {
        logic [KIND_W-1:0]                      kind;
        logic                                   flushed;
        logic [FLAG_W-1:0]                      flags;
        logic                                   all_set;
        logic [SETTING_COUNT-1:0][VALUE_W-1:0]  values;
    } t_parser_result;

    // Every input starts at a known value; reset is held from time zero.
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_mode   = MODE_BYTE;
    logic [7:0] in_byte   = 8'h00;
    logic       out_stall = 1'b0;

    logic                in_stall;
    logic                out_valid;
    logic [KIND_W-1:0]   frame_kind;
    logic                buffer_flushed;
    logic [FLAG_W-1:0]   arrival_flags;
    logic                all_settings_received;
    logic [VALUE_W-1:0]  air_direction;
    logic [VALUE_W-1:0]  air_speed;
    logic [VALUE_W-1:0]  seat_height;
    logic [VALUE_W-1:0]  seat_lateral;
    logic [VALUE_W-1:0]  side_height;
    logic [VALUE_W-1:0]  side_lateral;

    // The six stored settings side by side, in tag order, so that they can be checked in a loop.
    logic [SETTING_COUNT-1:0][VALUE_W-1:0] seen_values;
    assign seen_values = {side_lateral, side_height, seat_lateral, seat_height,
                          air_speed, air_direction};

    string value_names [SETTING_COUNT] = '{"air_direction", "air_speed", "seat_height",
                                           "seat_lateral", "side_height", "side_lateral"};

    logic [47:0] key_patterns [4] = '{PAT_KEY_CLOSE, PAT_KEY_FAR, PAT_KEY_OFF, PAT_KEY_ON};
    logic [7:0]  group_chars [3]  = '{CH_A, CH_C, CH_S};
    logic [7:0]  half_chars [2]   = '{CH_H, CH_L};

    // Idling rates in percent; the main sequence changes them from phase to phase.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    int items_sent     = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;

    // Results predicted for accepted input transactions, oldest first.
    t_parser_result pending_results [$];
    t_parser_result want;

    // Scratch space for the characters between the brackets of a frame being built.
    logic [7:0] body_bytes [$];

    // The testbench's own copy of the parser state.
    logic                model_open;
    int                  model_len;
    int                  model_fill;
    logic [7:0]          model_chars [6];
    logic [VALUE_W-1:0]  model_values [SETTING_COUNT];
    logic [FLAG_W-1:0]   model_flags;

    ascii_command_frame_parser #(
        .BUFFER_DEPTH(DEPTH)
    ) i_dut (
        .i_clk                  (clk),
        .i_rst_n                (rst_n),
        .i_in_valid             (in_valid),
        .o_in_stall             (in_stall),
        .i_mode                 (in_mode),
        .i_rx_byte              (in_byte),
        .o_out_valid            (out_valid),
        .i_out_stall            (out_stall),
        .o_frame_kind           (frame_kind),
        .o_buffer_flushed       (buffer_flushed),
        .o_arrival_flags        (arrival_flags),
        .o_all_settings_received(all_settings_received),
        .o_air_direction        (air_direction),
        .o_air_speed            (air_speed),
        .o_seat_height          (seat_height),
        .o_seat_lateral         (seat_lateral),
        .o_side_height          (side_height),
        .o_side_lateral         (side_lateral)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Model of the parser
    // ------------------------------------------------------------------

    function automatic logic is_decimal(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Decodes the six captured characters of a frame that has just been closed, applies its
    // effect to the model state and returns the kind that the parser should report.
    function automatic logic [KIND_W-1:0] decode_closed_frame();
        logic [47:0] body;
        int          grp;
        int          half;
        int          slot;
        body = {model_chars[0], model_chars[1], model_chars[2],
                model_chars[3], model_chars[4], model_chars[5]};
        if (model_len != 6) return KIND_BAD;
        if (model_chars[0] == CH_R) begin
            case (model_chars[1])
                CH_A:    grp = 0;
                CH_C:    grp = 1;
                CH_S:    grp = 2;
                default: return KIND_BAD;
            endcase
            case (model_chars[2])
                CH_H:    half = 0;
                CH_L:    half = 1;
                default: return KIND_BAD;
            endcase
            if (!is_decimal(model_chars[3]) || !is_decimal(model_chars[4]) ||
                !is_decimal(model_chars[5])) return KIND_BAD;
            slot = grp * 2 + half;
            model_values[slot] = VALUE_W'(int'(model_chars[3] - CH_ZERO) * 100 +
                                          int'(model_chars[4] - CH_ZERO) * 10 +
                                          int'(model_chars[5] - CH_ZERO));
            model_flags[slot] = 1'b1;
            return KIND_W'(KIND_RAH + slot);
        end
        // Close and far exclude each other; off and on are independent of everything else.
        if (body == PAT_KEY_CLOSE) begin
            model_flags[FLAG_CLOSE] = 1'b1;
            model_flags[FLAG_FAR]   = 1'b0;
            return KIND_CLOSE;
        end
        if (body == PAT_KEY_FAR) begin
            model_flags[FLAG_FAR]   = 1'b1;
            model_flags[FLAG_CLOSE] = 1'b0;
            return KIND_FAR;
        end
        if (body == PAT_KEY_OFF) begin
            model_flags[FLAG_OFF] = 1'b1;
            return KIND_OFF;
        end
        if (body == PAT_KEY_ON) begin
            model_flags[FLAG_ON] = 1'b1;
            return KIND_ON;
        end
        return KIND_BAD;
    endfunction

    // Advances the model by one accepted input transaction and returns the result that the
    // parser must deliver for it.
    function automatic t_parser_result predict_parser_step(input logic mode,
                                                           input logic [7:0] data);
        t_parser_result r;
        r.kind    = KIND_NONE;
        r.flushed = 1'b0;
        if (mode == MODE_CLEAR) begin
            // The receive buffer is left alone; only the flags are touched.
            model_flags &= ~CLEAR_MASK;
        end else begin
            model_fill++;
            if (!model_open) begin
                // Anything before an opening bracket, a stray '>' included, only fills the buffer.
                if (data == CH_OPEN) begin
                    model_open = 1'b1;
                    model_len  = 0;
                end
            end else if (data == CH_CLOSE) begin
                r.kind     = decode_closed_frame();
                model_open = 1'b0;
                model_len  = 0;
                model_fill = 0;
            end else begin
                // A second '<' is an ordinary character here; only six are kept.
                if (model_len < 6) model_chars[model_len] = data;
                if (model_len < 15) model_len++;
            end
            if (model_fill >= DEPTH - 1) begin
                model_fill = 0;
                model_open = 1'b0;
                model_len  = 0;
                r.flushed  = 1'b1;
            end
        end
        r.flags   = model_flags;
        r.all_set = &model_flags[SETTING_COUNT-1:0];
        for (int s = 0; s < SETTING_COUNT; s++) r.values[s] = model_values[s];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driving the input side
    // ------------------------------------------------------------------

    // Offers one input transaction, after a random number of idle cycles, and waits until the
    // parser takes it. The valid line is left high on return so that back-to-back transactions
    // follow without a gap; the drain task, or a next call that idles, lowers it at the next falling edge.
    task automatic send_item(input logic mode, input logic [7:0] data);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            in_mode  <= 1'($urandom);
            in_byte  <= 8'($urandom);
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_mode  <= mode;
        in_byte  <= data;
        forever begin
            @(posedge clk);
            if (!in_stall) break;
        end
        pending_results.push_back(predict_parser_step(mode, data));
        items_sent++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) send_item(MODE_BYTE, text[i]);
    endtask

    task automatic send_clear();
        send_item(MODE_CLEAR, 8'($urandom));
    endtask

    // Sends '<', the characters collected in body_bytes, then '>'.
    task automatic send_frame_body();
        send_item(MODE_BYTE, CH_OPEN);
        foreach (body_bytes[i]) send_item(MODE_BYTE, body_bytes[i]);
        send_item(MODE_BYTE, CH_CLOSE);
    endtask

    task automatic build_setting_body(input int slot, input int value);
        body_bytes.delete();
        body_bytes.push_back(CH_R);
        body_bytes.push_back(group_chars[slot / 2]);
        body_bytes.push_back(half_chars[slot % 2]);
        body_bytes.push_back(8'(CH_ZERO + value / 100));
        body_bytes.push_back(8'(CH_ZERO + (value / 10) % 10));
        body_bytes.push_back(8'(CH_ZERO + value % 10));
    endtask

    task automatic send_setting_frame(input int slot, input int value);
        build_setting_body(slot, value);
        send_frame_body();
    endtask

    task automatic send_key_frame(input logic [47:0] pattern);
        body_bytes.delete();
        for (int i = 0; i < 6; i++) body_bytes.push_back(pattern[47 - 8 * i -: 8]);
        send_frame_body();
    endtask

    function automatic logic [7:0] random_non_close();
        logic [7:0] c;
        do c = 8'($urandom); while (c == CH_CLOSE);
        return c;
    endfunction

    function automatic logic [7:0] random_non_digit();
        logic [7:0] c;
        do c = 8'($urandom); while (c == CH_CLOSE || is_decimal(c));
        return c;
    endfunction

    function automatic int random_setting_value();
        case ($urandom_range(7))
            0:       return 0;
            1:       return 999;
            default: return $urandom_range(999);
        endcase
    endfunction

    // Lowers valid and waits until every predicted result has been delivered.
    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // One frame for every setting tag, with the value extremes among them, then an overwrite.
    task automatic test_setting_frames();
        send_text("<RAH000>");
        send_text("<RAL999>");
        send_text("<RCH123>");
        send_text("<RCL908>");
        send_text("<RSH555>");
        send_text("<RSL001>");
        send_text("<RAH999>");
    endtask

    // All four key frames, with close and far each clearing the other.
    task automatic test_key_frames();
        send_key_frame(PAT_KEY_CLOSE);
        send_key_frame(PAT_KEY_FAR);
        send_key_frame(PAT_KEY_CLOSE);
        send_key_frame(PAT_KEY_OFF);
        send_key_frame(PAT_KEY_ON);
    endtask

    // Clear requests keep close and far, ignore the byte lane, and do not disturb a frame that
    // is half received.
    task automatic test_clear_requests();
        send_item(MODE_CLEAR, 8'hFF);
        send_item(MODE_CLEAR, 8'h00);
        send_text("<RSL042>");
        send_text("<RA");
        send_clear();
        send_text("H777>");
        send_clear();
    endtask

    // Frames that must be reported as unrecognised, and brackets in unusual places.
    task automatic test_malformed_frames();
        send_text("x>");
        send_text("<>");
        send_text("<<RAH12>");
        send_text("<RAH12>");
        send_text("<RCH12345678901234567>");
        send_text("<RAH1/3>");
        send_text("<RAL12:>");
        send_text("<RBH100>");
        send_text("<RAX100>");
        send_text("<WK0002>");
    endtask

    // The buffer flushes after 63 bytes with or without an open frame; a closing bracket on
    // the 63rd byte closes the frame instead.
    task automatic test_buffer_flush();
        repeat (DEPTH - 1) send_item(MODE_BYTE, "a");
        send_item(MODE_BYTE, CH_OPEN);
        repeat (DEPTH - 2) send_item(MODE_BYTE, "z");
        send_text("<RCL321>");
        repeat (DEPTH - 9) send_item(MODE_BYTE, "q");
        send_text("<RAH123>");
    endtask

    // A frame that is wrong in one of several ways, built with random content.
    task automatic send_broken_frame();
        int count;
        body_bytes.delete();
        case ($urandom_range(5))
            0: begin
                // A setting frame with one value character that is not a digit.
                build_setting_body($urandom_range(SETTING_COUNT - 1), random_setting_value());
                body_bytes[$urandom_range(5, 3)] = random_non_digit();
                send_frame_body();
            end
            1: begin
                // A body of random length, sometimes starting like a setting frame.
                count = $urandom_range(20);
                if ($urandom_range(1)) begin
                    body_bytes.push_back(CH_R);
                    body_bytes.push_back(group_chars[$urandom_range(2)]);
                end
                while (body_bytes.size() < count) body_bytes.push_back(random_non_close());
                send_frame_body();
            end
            2: begin
                // A setting frame with an arbitrary tag.
                build_setting_body($urandom_range(SETTING_COUNT - 1), random_setting_value());
                body_bytes[$urandom_range(2, 1)] = random_non_close();
                send_frame_body();
            end
            3: begin
                // A key frame with its last two characters drawn from a wider set.
                send_key_frame({PAT_KEY_FAR[47:16],
                                $urandom_range(3) == 0 ? random_non_close() : 8'("0"),
                                $urandom_range(1) == 0 ? random_non_close() : 8'("1")});
            end
            4: begin
                // An unterminated frame; whatever follows lands inside it.
                send_item(MODE_BYTE, CH_OPEN);
                count = $urandom_range(5, 1);
                repeat (count) send_item(MODE_BYTE, random_non_close());
            end
            default: begin
                // A valid setting frame with a clear request in the middle of it.
                build_setting_body($urandom_range(SETTING_COUNT - 1), random_setting_value());
                send_item(MODE_BYTE, CH_OPEN);
                count = $urandom_range(5);
                foreach (body_bytes[i]) begin
                    if (i == count) send_clear();
                    send_item(MODE_BYTE, body_bytes[i]);
                end
                send_item(MODE_BYTE, CH_CLOSE);
            end
        endcase
    endtask

    // A run of DEPTH - 2 to DEPTH + 6 bytes without a closing bracket, which may force a flush, open or not.
    task automatic send_flood();
        int count;
        count = $urandom_range(DEPTH + 6, DEPTH - 2);
        if ($urandom_range(1)) send_item(MODE_BYTE, CH_OPEN);
        repeat (count) send_item(MODE_BYTE, random_non_close());
    endtask

    // Mostly well-formed frames with random content, the rest clears, broken frames and noise.
    task automatic test_random_stream(input int n_items);
        int stop_at;
        int pick;
        int count;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                send_setting_frame($urandom_range(SETTING_COUNT - 1), random_setting_value());
            end else if (pick < 55) begin
                send_key_frame(key_patterns[$urandom_range(3)]);
            end else if (pick < 62) begin
                send_clear();
            end else if (pick < 82) begin
                send_broken_frame();
            end else if (pick < 97) begin
                count = $urandom_range(6, 1);
                repeat (count) send_item(MODE_BYTE, 8'($urandom));
            end else begin
                send_flood();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls, result checking and the hang watchdog
    // ------------------------------------------------------------------

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic void check_field(input string field, input logic [31:0] expected,
                                        input logic [31:0] actual);
        if (expected !== actual) begin
            $error("%s mismatch: expected %0d, got %0d", field, expected, actual);
            mismatch_count++;
        end
    endfunction

    // Each result transaction is compared with the oldest prediction that is still waiting.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no prediction waiting: frame_kind %0d",
                       frame_kind);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("frame_kind", want.kind, frame_kind);
                check_field("buffer_flushed", want.flushed, buffer_flushed);
                check_field("arrival_flags", want.flags, arrival_flags);
                check_field("all_settings_received", want.all_set, all_settings_received);
                for (int s = 0; s < SETTING_COUNT; s++)
                    check_field(value_names[s], want.values[s], seen_values[s]);
            end
        end
    end

    // A run in which no transaction moves on either side for too long has hung.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HANG_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        model_open  = 1'b0;
        model_len   = 0;
        model_fill  = 0;
        model_flags = '0;
        foreach (model_chars[i]) model_chars[i] = 8'h00;
        foreach (model_values[i]) model_values[i] = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // First phase: the sender idles a little and the receiver stalls a lot.
        send_idle_pct = 26;
        recv_idle_pct = 76;
        test_setting_frames();
        test_key_frames();
        test_clear_requests();
        test_malformed_frames();
        test_buffer_flush();
        wait_for_results();
        test_random_stream(390);
        wait_for_results();

        // Second phase: the roles are swapped.
        send_idle_pct = 76;
        recv_idle_pct = 26;
        test_random_stream(390);
        wait_for_results();

        // Last phase: transactions back to back on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_stream(376);
        wait_for_results();

        repeat (4) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule : tb_top

`default_nettype wire
